// ===== rtl/gmm_background_subtractor_core_assert.svh =====
// ----------------------------------------------------------------------------
// gmm background subtractor assertion macros
// shared property forms for the core, clocked on clk_i, idle in reset
// ----------------------------------------------------------------------------
`ifndef GMM_BACKGROUND_SUBTRACTOR_CORE_ASSERT_SVH
`define GMM_BACKGROUND_SUBTRACTOR_CORE_ASSERT_SVH

// same-cycle implication
`define GMMBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gmmbs: same-cycle check failed");

// next-cycle implication
`define GMMBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gmmbs: next-cycle check failed");

`endif

// ===== rtl/gmmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gmmbs_pkg
// widths, codes, reset values and types of the gmm background subtractor
// ----------------------------------------------------------------------------
package gmmbs_pkg;

  localparam int unsigned GMMBS_COMPONENTS   = 4;
  localparam int unsigned GMMBS_FRAME_PIXELS = 16384;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned W_W       = 16;
  localparam int unsigned M_W       = 8;
  localparam int unsigned V_W       = 24;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LRATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WTHR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IVAR  = 2'd3;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_SEED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRAIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd3;

  localparam logic [W_W-1:0] LRATE_RST = 16'd328;
  localparam logic [W_W-1:0] WTHR_RST  = 16'd45875;
  localparam logic [V_W-1:0] IVAR_RST  = 24'd3840;

  typedef struct packed {
    logic [V_W-1:0] v;
    logic [M_W-1:0] m;
    logic [W_W-1:0] w;
  } comp_t;

  typedef struct packed {
    logic           start;
    logic [W_W-1:0] num;
    logic [W_W-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/gmmbs_div.sv =====
// ----------------------------------------------------------------------------
// gmmbs_div
// radix-2 restoring divider for (num << 16) / den with num below den
// ----------------------------------------------------------------------------
module gmmbs_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gmmbs_pkg::div_req_t     req_i,
  output logic                    done_o,
  output logic [gmmbs_pkg::W_W-1:0] quot_o
);
  import gmmbs_pkg::*;

  localparam int unsigned CW = $clog2(W_W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W_W-1:0] rem_q, quot_q, den_q;
  logic [W_W:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? W_W'(rem_sh - {1'b0, den_q}) : rem_sh[W_W-1:0];
      quot_q <= {quot_q[W_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/gmm_background_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// gmm_background_subtractor_core
// per-pixel gaussian mixture background model with seed, train, count, detect
// ----------------------------------------------------------------------------
// One pixel word is handled at a time. Each pixel's COMPONENTS components
// (weight Q0.16, mean, variance Q16.8) sit in one wide row of a synchronous
// model memory; the background count sits in a second memory. In train mode
// a word is read, worked on in a small component register file by a sequencer
// and written back before the next word is taken. Seed writes its row directly,
// detect may wait on the result register and count walks the components until
// the weight threshold is met or the last one is summed. Train walks every
// component, waits on the shared divider for each matching component whose
// learning ratio stays below one, and then sorts by weight/variance one pair
// at a time. The mode and the other registers may be written only while the
// core is idle. Only detect returns a word.
// ----------------------------------------------------------------------------
module gmm_background_subtractor_core #(
  parameter int unsigned COMPONENTS   = gmmbs_pkg::GMMBS_COMPONENTS,
  parameter int unsigned FRAME_PIXELS = gmmbs_pkg::GMMBS_FRAME_PIXELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gmmbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gmmbs_pkg::CFG_W-1:0]   cfg_data_i,
  // pixel input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gmmbs_pkg::PIX_W-1:0]   pixel_i,
  input  logic [gmmbs_pkg::ADDR_W-1:0]  pixel_address_i,
  // classification output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gmmbs_pkg::ADDR_W-1:0]  result_address_o,
  output logic                          foreground_o
);
  import gmmbs_pkg::*;

  localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned KW = $clog2(COMPONENTS);
  localparam int unsigned SW = W_W + KW + 1;
  localparam logic [KW-1:0] LAST = KW'(COMPONENTS - 1);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ISSUE  = 5'd1;
  localparam logic [4:0] S_LOAD   = 5'd2;
  localparam logic [4:0] S_MATCH  = 5'd3;
  localparam logic [4:0] S_WT     = 5'd4;
  localparam logic [4:0] S_DIV    = 5'd5;
  localparam logic [4:0] S_MEAN   = 5'd6;
  localparam logic [4:0] S_VAR    = 5'd7;
  localparam logic [4:0] S_SLOAD  = 5'd8;
  localparam logic [4:0] S_SL     = 5'd9;
  localparam logic [4:0] S_SR     = 5'd10;
  localparam logic [4:0] S_SCMP   = 5'd11;
  localparam logic [4:0] S_SSTORE = 5'd12;
  localparam logic [4:0] S_REPL   = 5'd13;
  localparam logic [4:0] S_SCAN   = 5'd14;
  localparam logic [4:0] S_WB     = 5'd15;
  localparam logic [4:0] S_SUM    = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  // address wrap by binary long reduction, eight compare/subtract steps
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] raw);
    logic [ADDR_W-1:0] rem;
    rem = raw;
    for (int i = 7; i >= 0; i--) begin
      if (32'(rem) >= (32'(FRAME_PIXELS) << i)) begin
        rem = rem - ADDR_W'(32'(FRAME_PIXELS) << i);
      end
    end
    return rem;
  endfunction

  // component counts as background when the pixel is within 2.5 times the variance, clamped to 255
  function automatic logic is_near(input logic [PIX_W-1:0] pix, input comp_t c);
    logic [PIX_W-1:0] dif;
    logic [V_W+2:0]   v5;
    logic [V_W-7:0]   t;
    logic [PIX_W-1:0] thr;
    dif = (pix >= c.m) ? pix - c.m : c.m - pix;
    v5  = {3'b000, c.v} + {1'b0, c.v, 2'b00};
    t   = v5[V_W+2:9];
    thr = (t > (V_W-6)'(255)) ? 8'hff : t[PIX_W-1:0];
    return dif < thr;
  endfunction

  // configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [W_W-1:0]    lr_q, wthr_q;
  logic [V_W-1:0]    ivar_q;

  // control
  logic [4:0]    state_q, state_d;
  logic [KW-1:0] k_q, k_d, kk_q, kk_d, rr_q, rr_d;
  logic          hit_q, hit_d, found_q, found_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [PIX_W-1:0]  pix_q;
  logic [ADDR_W-1:0] raw_q;
  logic [AW-1:0]     addr_q;
  comp_t             comp_q [COMPONENTS];
  comp_t             cur_q;
  logic [PIX_W-1:0]  ad_q;
  logic [V_W-1:0]    dis8_q, mag_q;
  logic              match_q, vup_q;
  logic [W_W:0]      rho_q;
  logic [W_W+V_W-1:0] lhs_q, rhs_q;
  logic [SW-1:0]     sum_q;
  logic              fg_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_fg_q;

  // model memories
  comp_t [COMPONENTS-1:0] row_mem [FRAME_PIXELS];
  comp_t [COMPONENTS-1:0] rd_row_q, row_wdata, seed_row;
  logic [CNT_W-1:0]       cnt_mem [FRAME_PIXELS];
  logic [CNT_W-1:0]       cnt_rd_q, cnt_wdata;
  logic                   row_we, cnt_we, rd_en;

  // datapath signals
  comp_t              cur_k, cur_r;
  logic [PIX_W-1:0]   ad_c;
  logic [2*PIX_W-1:0] sq_c;
  logic [V_W-1:0]     dis8_c;
  logic [V_W+1:0]     var3_c;
  logic               match_c;
  logic [W_W:0]       wop;
  logic [2*W_W:0]     wprod;
  logic [W_W+1:0]     grow_sum;
  logic [W_W-1:0]     new_w;
  logic [W_W+PIX_W:0] mprod;
  logic [M_W-1:0]     new_m;
  logic [W_W+V_W+1:0] vprod;
  logic [V_W-1:0]     new_v;
  logic [2*W_W-1:0]   dprod;
  logic [W_W-1:0]     decay_w;
  logic [W_W+V_W-1:0] lhs_c, rhs_c;
  logic [SW-1:0]      sum_c;
  logic               sum_done;
  logic [CNT_W-1:0]   n_clamp;
  logic               bg;
  logic               accept, out_free, out_load;
  div_req_t           div_req;
  logic               div_done;
  logic [W_W-1:0]     div_quot;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_OUT) && out_free;

  // ---------------------------------------------------------------------------
  // per-component arithmetic on the register file entries picked by k and rr
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_k   = comp_q[k_q];
    cur_r   = comp_q[rr_q];
    // match test: squared distance in Q16.8 against three variances
    ad_c    = (pix_q >= cur_k.m) ? pix_q - cur_k.m : cur_k.m - pix_q;
    sq_c    = ad_c * ad_c;
    dis8_c  = {sq_c, 8'h00};
    var3_c  = {2'b00, cur_k.v} + {1'b0, cur_k.v, 1'b0};
    match_c = {2'b00, dis8_c} < var3_c;
    // weight grows toward one on a match, decays otherwise
    wop      = match_q ? ((W_W+1)'(1) << W_W) - {1'b0, cur_k.w} : {1'b0, cur_k.w};
    wprod    = lr_q * wop;
    grow_sum = {2'b00, cur_k.w} + {1'b0, wprod[2*W_W:W_W]};
    if (match_q) begin
      new_w = (grow_sum > (W_W+2)'(16'hffff)) ? 16'hffff : grow_sum[W_W-1:0];
    end else begin
      new_w = cur_k.w - wprod[2*W_W-1:W_W];
    end
    // mean moves toward the pixel
    mprod = rho_q * ad_q;
    new_m = (pix_q >= cur_k.m) ? cur_k.m + mprod[W_W+PIX_W-1:W_W]
                               : cur_k.m - mprod[W_W+PIX_W-1:W_W];
    // variance moves toward the squared distance
    vprod = rho_q * mag_q;
    new_v = vup_q ? cur_k.v + vprod[W_W+V_W-1:W_W] : cur_k.v - vprod[W_W+V_W-1:W_W];
    // plain decay for the replacement sweep
    dprod   = lr_q * cur_k.w;
    decay_w = cur_k.w - dprod[2*W_W-1:W_W];
    // sort cross products, weight over variance without a division
    lhs_c = cur_r.w * cur_q.v;
    rhs_c = cur_q.w * cur_r.v;
    // cumulative weight for the count
    sum_c    = sum_q + SW'(cur_k.w);
    sum_done = (sum_c >= SW'(wthr_q)) || (k_q == LAST);
  end

  // detect: every counted component tested side by side
  always_comb begin
    n_clamp = (cnt_rd_q > CNT_W'(COMPONENTS)) ? CNT_W'(COMPONENTS) : cnt_rd_q;
    bg      = 1'b0;
    for (int i = 0; i < COMPONENTS; i++) begin
      if ((CNT_W'(i) < n_clamp) && is_near(pix_q, rd_row_q[i])) begin
        bg = 1'b1;
      end
    end
  end

  // seed row: component 0 takes the pixel at full weight
  always_comb begin
    for (int i = 0; i < COMPONENTS; i++) begin
      seed_row[i].w = (i == 0) ? 16'hffff : '0;
      seed_row[i].m = (i == 0) ? pix_q : 8'hff;
      seed_row[i].v = ivar_q;
    end
  end

  always_comb begin
    for (int i = 0; i < COMPONENTS; i++) begin
      row_wdata[i] = (state_q == S_WB) ? comp_q[i] : seed_row[i];
    end
  end

  assign rd_en     = state_q == S_ISSUE;
  assign row_we    = ((state_q == S_ISSUE) && (mode_q == MODE_SEED)) || (state_q == S_WB);
  assign cnt_we    = (state_q == S_SUM) && sum_done;
  assign cnt_wdata = CNT_W'(k_q) + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    kk_d        = kk_q;
    rr_d        = rr_q;
    hit_d       = hit_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    div_req.start = 1'b0;
    div_req.num   = lr_q;
    div_req.den   = new_w;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_ISSUE;
      end
      S_ISSUE: begin
        state_d = (mode_q == MODE_SEED) ? S_IDLE : S_LOAD;
      end
      S_LOAD: begin
        k_d = '0;
        unique case (mode_q)
          MODE_TRAIN: begin
            hit_d   = 1'b0;
            state_d = S_MATCH;
          end
          MODE_COUNT:  state_d = S_SUM;
          MODE_DETECT: state_d = S_OUT;
          default:     state_d = S_IDLE;
        endcase
      end
      S_MATCH: begin
        hit_d   = hit_q || match_c;
        state_d = S_WT;
      end
      S_WT: begin
        if (match_q && (new_w != '0)) begin
          if (lr_q >= new_w) begin
            state_d = S_MEAN;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end else if (k_q == LAST) begin
          kk_d    = '0;
          state_d = S_SLOAD;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = S_MATCH;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_MEAN;
      end
      S_MEAN: state_d = S_VAR;
      S_VAR: begin
        if (k_q == LAST) begin
          kk_d    = '0;
          state_d = S_SLOAD;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = S_MATCH;
        end
      end
      S_SLOAD: begin
        if (kk_q == LAST) begin
          state_d = S_REPL;
        end else begin
          rr_d    = kk_q + KW'(1);
          state_d = S_SL;
        end
      end
      S_SL: state_d = S_SR;
      S_SR: state_d = S_SCMP;
      S_SCMP: begin
        if (rr_q == LAST) begin
          state_d = S_SSTORE;
        end else begin
          rr_d    = rr_q + KW'(1);
          state_d = S_SL;
        end
      end
      S_SSTORE: begin
        kk_d    = kk_q + KW'(1);
        state_d = S_SLOAD;
      end
      S_REPL: begin
        if (!hit_q && (comp_q[LAST].w == '0)) begin
          k_d     = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_WB;
        end
      end
      S_SCAN: begin
        if (!found_q && (cur_k.w == '0)) found_d = 1'b1;
        if (k_q == LAST) begin
          state_d = S_WB;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_WB: state_d = S_IDLE;
      S_SUM: begin
        if (sum_done) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      kk_q        <= '0;
      rr_q        <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_SEED;
      lr_q        <= LRATE_RST;
      wthr_q      <= WTHR_RST;
      ivar_q      <= IVAR_RST;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      kk_q        <= kk_d;
      rr_q        <= rr_d;
      hit_q       <= hit_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE:  mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_LRATE: lr_q   <= cfg_data_i[W_W-1:0];
          CFG_WTHR:  wthr_q <= cfg_data_i[W_W-1:0];
          CFG_IVAR:  ivar_q <= cfg_data_i[V_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // component register file and working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= pixel_i;
      raw_q  <= pixel_address_i;
      addr_q <= AW'(wrap_addr(pixel_address_i));
    end
    unique case (state_q)
      S_LOAD: begin
        for (int i = 0; i < COMPONENTS; i++) comp_q[i] <= rd_row_q[i];
        sum_q <= '0;
        fg_q  <= !bg;
      end
      S_MATCH: begin
        ad_q    <= ad_c;
        dis8_q  <= dis8_c;
        match_q <= match_c;
      end
      S_WT: begin
        comp_q[k_q].w <= new_w;
        rho_q         <= (W_W+1)'(1) << W_W;   // ratio saturates at one
      end
      S_DIV: begin
        if (div_done) rho_q <= {1'b0, div_quot};
      end
      S_MEAN: begin
        comp_q[k_q].m <= new_m;
        vup_q <= dis8_q >= cur_k.v;
        mag_q <= (dis8_q >= cur_k.v) ? dis8_q - cur_k.v : cur_k.v - dis8_q;
      end
      S_VAR:  comp_q[k_q].v <= new_v;
      S_SLOAD: cur_q <= comp_q[kk_q];
      S_SL:   lhs_q <= lhs_c;
      S_SR:   rhs_q <= rhs_c;
      S_SCMP: begin
        if (lhs_q > rhs_q) begin
          cur_q        <= comp_q[rr_q];
          comp_q[rr_q] <= cur_q;
        end
      end
      S_SSTORE: comp_q[kk_q] <= cur_q;
      S_REPL: begin
        // nothing matched and the weakest slot is in use: take it over
        if (!hit_q && (comp_q[LAST].w != '0)) begin
          comp_q[LAST].m <= pix_q;
          comp_q[LAST].v <= ivar_q;
        end
      end
      S_SCAN: begin
        // first empty slot takes the pixel, every other weight decays
        if (!found_q && (cur_k.w == '0)) begin
          comp_q[k_q].w <= lr_q;
          comp_q[k_q].m <= pix_q;
          comp_q[k_q].v <= ivar_q;
        end else begin
          comp_q[k_q].w <= decay_w;
        end
      end
      S_SUM: sum_q <= sum_c;
      S_OUT: begin
        if (out_free) begin
          out_addr_q <= raw_q;
          out_fg_q   <= fg_q;
        end
      end
      default: ;
    endcase
  end

  // model memories, synchronous read registered into the next cycle
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[addr_q] <= row_wdata;
    if (rd_en)  rd_row_q <= row_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[addr_q] <= cnt_wdata;
    if (rd_en)  cnt_rd_q <= cnt_mem[addr_q];
  end

  gmmbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ready_o       = state_q == S_IDLE;
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign foreground_o     = out_fg_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `include "gmm_background_subtractor_core_assert.svh"

  `GMMBS_ASSERT_IMP(a_row_we_mode, row_we, mode_q == MODE_SEED || mode_q == MODE_TRAIN)
  `GMMBS_ASSERT_IMP(a_cnt_we_mode, cnt_we, mode_q == MODE_COUNT)
  `GMMBS_ASSERT_IMP(a_out_mode, out_load, mode_q == MODE_DETECT)
  `GMMBS_ASSERT_NXT(a_div_wait, div_req.start, state_q == S_DIV && !div_done)

endmodule

// ===== bench/tb_gmm_background_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// tb_gmm_background_subtractor_core
// self-checking bench: a mixture model kept in step with the core predicts
// every detect word, while seed, train and count rounds with varied learning
// rate, threshold and initial variance build the per-pixel model
// ----------------------------------------------------------------------------
module tb_gmm_background_subtractor_core;
  import gmmbs_pkg::*;

  localparam int unsigned NCOMP      = GMMBS_COMPONENTS;
  localparam int unsigned ITEM_GOAL  = 1150;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned SETTLE     = 200;   // above worst train time
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned QUIET_FROM = 1000;

  // one expected classification
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              fg;
  } verdict_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the mixture model and registers
  // --------------------------------------------------------------------------
  class mixture_scoreboard;
    bit [W_W-1:0]   wt[];
    bit [M_W-1:0]   mn[];
    bit [V_W-1:0]   vr[];
    bit [CNT_W-1:0] cnt[];
    bit [MODE_W-1:0] op;
    int unsigned lrate, wthr, ivar;
    verdict_t verdicts[$];
    int unsigned errors;

    function new();
      wt  = new[GMMBS_FRAME_PIXELS * NCOMP];
      mn  = new[GMMBS_FRAME_PIXELS * NCOMP];
      vr  = new[GMMBS_FRAME_PIXELS * NCOMP];
      cnt = new[GMMBS_FRAME_PIXELS];
      op = MODE_SEED;
      lrate = LRATE_RST;
      wthr = WTHR_RST;
      ivar = IVAR_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_MODE:  op = data[MODE_W-1:0];
        CFG_LRATE: lrate = data[15:0];
        CFG_WTHR:  wthr = data[15:0];
        CFG_IVAR:  ivar = data[V_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned decayed(int unsigned w);
      return w - ((lrate * w) >> 16);
    endfunction

    function int unsigned grown(int unsigned w);
      longint unsigned n;
      n = w + ((longint'(lrate) * (65536 - w)) >> 16);
      return (n > 65535) ? 65535 : int'(n);
    endfunction

    function longint unsigned step_to(longint unsigned cur, longint unsigned tgt,
                                      longint unsigned rho);
      if (tgt >= cur) return cur + ((rho * (tgt - cur)) >> 16);
      return cur - ((rho * (cur - tgt)) >> 16);
    endfunction

    function void swap_comp(int unsigned a, int unsigned b);
      bit [W_W-1:0] tw;
      bit [M_W-1:0] tm;
      bit [V_W-1:0] tv;
      tw = wt[a]; tm = mn[a]; tv = vr[a];
      wt[a] = wt[b]; mn[a] = mn[b]; vr[a] = vr[b];
      wt[b] = tw; mn[b] = tm; vr[b] = tv;
    endfunction

    function void train(int unsigned base, int unsigned pix);
      int unsigned i, mu, ad, dis8, w, rho, misses, lst;
      longint unsigned var_q, lhs, rhs;
      misses = 0;
      for (int k = 0; k < NCOMP; k++) begin
        i = base + k;
        mu = mn[i];
        ad = (pix > mu) ? pix - mu : mu - pix;
        dis8 = (ad * ad) << 8;
        var_q = vr[i];
        if (longint'(dis8) < 3 * var_q) begin
          w = grown(wt[i]);
          wt[i] = w;
          if (w != 0) begin
            rho = (lrate << 16) / w;
            if (rho > 65536) rho = 65536;
            mn[i] = step_to(mu, pix, rho);
            vr[i] = step_to(var_q, dis8, rho);
          end
        end else begin
          wt[i] = decayed(wt[i]);
          misses++;
        end
      end
      // order by weight over variance, via cross products
      for (int k = 0; k < NCOMP; k++)
        for (int r = k; r < NCOMP; r++) begin
          lhs = longint'(wt[base + r]) * vr[base + k];
          rhs = longint'(wt[base + k]) * vr[base + r];
          if (lhs > rhs) swap_comp(base + r, base + k);
        end
      // nothing matched: take a free slot, else overwrite the weakest
      if (misses == NCOMP) begin
        lst = base + NCOMP - 1;
        if (wt[lst] == 0) begin
          for (int k = 0; k < NCOMP; k++)
            if (wt[base + k] == 0) begin
              wt[base + k] = lrate;
              mn[base + k] = pix;
              vr[base + k] = ivar;
              for (int r = 0; r < NCOMP; r++)
                if (r != k) wt[base + r] = decayed(wt[base + r]);
              break;
            end
        end else begin
          mn[lst] = pix;
          vr[lst] = ivar;
        end
      end
    endfunction

    function bit classify(int unsigned base, int unsigned addr, int unsigned pix);
      int unsigned n, mu, ad;
      longint unsigned thr;
      n = cnt[addr];
      if (n > NCOMP) n = NCOMP;
      for (int a = 0; a < n; a++) begin
        mu = mn[base + a];
        ad = (pix > mu) ? pix - mu : mu - pix;
        thr = (longint'(vr[base + a]) * 5) >> 9;
        if (thr > 255) thr = 255;
        if (ad < thr) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic [ADDR_W-1:0] addr);
      int unsigned base, sum, n;
      verdict_t v;
      base = addr * NCOMP;
      case (op)
        MODE_SEED: begin
          for (int k = 0; k < NCOMP; k++) begin
            wt[base + k] = (k == 0) ? 16'hFFFF : 16'h0;
            mn[base + k] = (k == 0) ? pix : 8'hFF;
            vr[base + k] = ivar;
          end
        end
        MODE_TRAIN: train(base, pix);
        MODE_COUNT: begin
          sum = 0;
          n = NCOMP;
          for (int a = 0; a < NCOMP; a++) begin
            sum += wt[base + a];
            if (sum >= wthr) begin
              n = a + 1;
              break;
            end
          end
          cnt[addr] = n;
        end
        default: begin
          v.addr = addr;
          v.fg = classify(base, addr, pix);
          verdicts.push_back(v);
        end
      endcase
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic fg);
      verdict_t v;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: addr %0d fg %0b", addr, fg);
        return;
      end
      v = verdicts.pop_front();
      if (addr !== v.addr || fg !== v.fg) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: addr exp %0d got %0d, fg exp %0b got %0b",
                   v.addr, addr, v.fg, fg);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [PIX_W-1:0] pixel_i = '0;
  logic [ADDR_W-1:0] pixel_address_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o, foreground_o;
  logic [ADDR_W-1:0] result_address_o;

  always #4 clk_i = ~clk_i;

  gmm_background_subtractor_core dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .pixel_i, .pixel_address_i,
    .out_valid_o, .out_ready_i, .result_address_o, .foreground_o
  );

  mixture_scoreboard board = new();

  int unsigned sent = 0;
  bit quiet = 1'b0;      // no idling in the last part of the run
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int unsigned cycles = 0;

  // ---- monitors: everything sampled at the edge that completes a handshake
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) board.set_reg(cfg_index_i, cfg_data_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_pixel(pixel_i, pixel_address_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(result_address_o, foreground_o);
  end

  // ---- watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_gmm_background_subtractor_core: FAIL");
      $finish;
    end
  end

  // ---- result side: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_pixel(input int unsigned pix, input int unsigned addr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= pix;
    pixel_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // stop offering words and wait for every verdict to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.verdicts.size() != 0) @(posedge clk_i);
  endtask

  // register write; the caller must wait until the core has gone idle, the task does not check
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic settle_and_set_mode(input logic [MODE_W-1:0] m);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(CFG_MODE, m);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int unsigned pool[32];
  bit seeded[int unsigned];
  bit counted[int unsigned];
  int unsigned bg[int unsigned];   // per-address background grey level

  initial begin
    int unsigned round_addr[6];
    int unsigned a, p, lr, th, iv;
    int unsigned rnd;

    pool[0] = 0;
    pool[1] = 16383;
    for (int i = 2; i < 32; i++) pool[i] = $urandom_range(0, 16383);
    foreach (pool[i]) bg[pool[i]] = $urandom_range(0, 255);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed: all four operations, field extremes, new component,
    // ---- overwrite of the weakest slot, zero initial variance
    send_pixel(0, 0);
    send_pixel(255, 16383);
    send_pixel(128, pool[2]);
    seeded[0] = 1; seeded[16383] = 1; seeded[pool[2]] = 1;
    settle_and_set_mode(MODE_TRAIN);
    send_pixel(0, 0);          // exact match
    send_pixel(200, 0);        // no match, free slot taken
    send_pixel(90, 0);         // another new component
    send_pixel(30, 0);
    send_pixel(160, 0);        // no free slot left
    send_pixel(255, 16383);
    send_pixel(0, 16383);
    send_pixel(130, pool[2]);
    settle_and_set_mode(MODE_COUNT);
    send_pixel(0, 0);
    send_pixel(255, 16383);
    send_pixel(7, pool[2]);
    counted[0] = 1; counted[16383] = 1; counted[pool[2]] = 1;
    settle_and_set_mode(MODE_DETECT);
    send_pixel(0, 0);
    send_pixel(255, 0);
    send_pixel(160, 0);
    send_pixel(255, 16383);
    send_pixel(0, 16383);
    send_pixel(128, pool[2]);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(CFG_IVAR, 0);     // zero variance: new components can never match
    cfg_valid_i <= 1'b0;
    settle_and_set_mode(MODE_TRAIN);
    send_pixel(0, 0);
    send_pixel(130, pool[2]);
    settle_and_set_mode(MODE_DETECT);
    send_pixel(0, 0);

    // ---- random rounds: seed, train, count, detect with varied registers
    rnd = 0;
    while (sent < ITEM_GOAL) begin
      case ($urandom_range(0, 3))
        0: lr = 0;
        1: lr = 65535;
        2: lr = LRATE_RST;
        default: lr = $urandom_range(1, 8000);
      endcase
      case ($urandom_range(0, 3))
        0: th = 0;
        1: th = 65535;
        2: th = WTHR_RST;
        default: th = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: iv = 0;
        1: iv = 24'hFFFFFF;
        2: iv = IVAR_RST;
        3: iv = $urandom_range(0, 24'hFFFFFF);
        default: iv = $urandom_range(256, 40000);
      endcase
      drain();
      repeat (SETTLE) @(posedge clk_i);
      // upper data bits set at random, the core keeps only the register width
      write_reg(CFG_LRATE, lr | ($urandom_range(0, 255) << 16));
      write_reg(CFG_WTHR, th | ($urandom_range(0, 255) << 16));
      write_reg(CFG_IVAR, iv);
      write_reg(CFG_MODE, MODE_SEED);
      cfg_valid_i <= 1'b0;

      foreach (round_addr[i]) round_addr[i] = pool[$urandom_range(0, 31)];
      foreach (round_addr[i]) begin
        if (rnd % 3 == 0 || !seeded.exists(round_addr[i])) begin
          send_pixel(bg[round_addr[i]], round_addr[i]);
          seeded[round_addr[i]] = 1;
        end
      end

      settle_and_set_mode(MODE_TRAIN);
      repeat (40) begin
        a = round_addr[$urandom_range(0, 5)];
        // mostly a noisy steady background, sometimes an intruder
        if ($urandom_range(0, 6) == 0) p = $urandom_range(0, 255);
        else begin
          p = bg[a] + $urandom_range(0, 12);
          p = (p < 6) ? 0 : p - 6;
          if (p > 255) p = 255;
        end
        send_pixel(p, a);
      end

      settle_and_set_mode(MODE_COUNT);
      foreach (round_addr[i]) begin
        send_pixel($urandom_range(0, 255), round_addr[i]);
        counted[round_addr[i]] = 1;
      end

      settle_and_set_mode(MODE_DETECT);
      if (rnd == 3) hold_req = 1'b1;   // result side stalls, input backs up
      for (int j = 0; j < 30; j++) begin
        a = round_addr[$urandom_range(0, 5)];
        if (j == 15 && rnd == 5) drain();
        if ($urandom_range(0, 1) == 0) p = $urandom_range(0, 255);
        else begin
          p = bg[a] + $urandom_range(0, 20);
          p = (p < 10) ? 0 : p - 10;
          if (p > 255) p = 255;
        end
        send_pixel(p, a);
      end
      if (sent > QUIET_FROM) quiet = 1'b1;
      rnd++;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0 && board.verdicts.size() == 0)
      $display("tb_gmm_background_subtractor_core: PASS");
    else
      $display("tb_gmm_background_subtractor_core: FAIL");
    $finish;
  end

endmodule
